>>> rtl/zpwf_pkg.sv
// ----------------------------------------------------------------------------
// zpwf_pkg
// Shared types and constants for the zero-padded window filter.
// ----------------------------------------------------------------------------
package zpwf_pkg;

  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = 10;
  localparam int DIM_W      = 11;
  localparam int VAL_W      = 14;
  localparam int SX_W       = 11;
  localparam int SQ_W       = 2 * SX_W;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    MODE_LAP        = 2'd0,
    MODE_LAP_CENTRE = 2'd1,
    MODE_SOBEL      = 2'd2,
    MODE_BOX        = 2'd3
  } mode_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    mode_t            filter_mode;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] filtered_value;
    logic                    is_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_GLAST,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic gather;
    logic sq_x;
    logic sq_y;
    logic root_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic emit_go;
    logic gather_last;
    logic is_sobel;
    logic root_done;
    logic out_free;
  } status_t;

endpackage

>>> rtl/zpwf_controller.sv
// ----------------------------------------------------------------------------
// zpwf_controller
// Sequencer: accept, gather window, optional root, load result.
// ----------------------------------------------------------------------------
module zpwf_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  zpwf_pkg::status_t  status,
  output zpwf_pkg::cmd_t     cmd
);

  zpwf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zpwf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      zpwf_pkg::ST_IDLE: begin
        if (req_valid && status.emit_go) state_next = zpwf_pkg::ST_GATHER;
      end
      zpwf_pkg::ST_GATHER: begin
        if (status.gather_last) state_next = zpwf_pkg::ST_GLAST;
      end
      zpwf_pkg::ST_GLAST: begin
        state_next = status.is_sobel ? zpwf_pkg::ST_SQX : zpwf_pkg::ST_FINISH;
      end
      zpwf_pkg::ST_SQX:  state_next = zpwf_pkg::ST_SQY;
      zpwf_pkg::ST_SQY:  state_next = zpwf_pkg::ST_ROOT;
      zpwf_pkg::ST_ROOT: begin
        if (status.root_done) state_next = zpwf_pkg::ST_FINISH;
      end
      zpwf_pkg::ST_FINISH: begin
        if (status.out_free) state_next = zpwf_pkg::ST_IDLE;
      end
      default: state_next = zpwf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready     = (state == zpwf_pkg::ST_IDLE);
    cmd           = '0;
    cmd.accept    = (state == zpwf_pkg::ST_IDLE) && req_valid;
    cmd.gather    = (state == zpwf_pkg::ST_GATHER);
    cmd.sq_x      = (state == zpwf_pkg::ST_SQX);
    cmd.sq_y      = (state == zpwf_pkg::ST_SQY);
    cmd.root_step = (state == zpwf_pkg::ST_ROOT);
    cmd.finish    = (state == zpwf_pkg::ST_FINISH) && status.out_free;
  end

endmodule

>>> rtl/zpwf_datapath.sv
// ----------------------------------------------------------------------------
// zpwf_datapath
// Line store, stream counters, window accumulators, root unit, output word.
// ----------------------------------------------------------------------------
module zpwf_datapath #(
  parameter int MAX_WIDTH   = 1024,
  parameter int WINDOW_SIZE = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  zpwf_pkg::cfg_t       cfg,
  input  logic                 cfg_clear,
  input  zpwf_pkg::in_item_t   req,
  input  zpwf_pkg::cmd_t       cmd,
  output zpwf_pkg::status_t    status,
  output zpwf_pkg::out_item_t  res,
  output logic                 res_valid,
  input  logic                 res_ready
);

  localparam int RAD   = WINDOW_SIZE / 2;
  localparam int SPAN  = 2 * RAD + 1;
  localparam int LINES = 2 * WINDOW_SIZE;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int TW    = WW + zpwf_pkg::DIM_W;
  localparam int SW    = $clog2(LINES);
  localparam int AW    = $clog2(LINES * MAX_WIDTH);
  localparam int KW    = $clog2(SPAN);
  localparam int CS    = CW + 2;
  localparam int RS    = zpwf_pkg::ROW_W + 2;
  localparam int STW   = SW + 2;
  localparam int AC    = zpwf_pkg::VAL_W;
  localparam int SXW   = zpwf_pkg::SX_W;
  localparam int SQW   = zpwf_pkg::SQ_W;

  logic [7:0] mem [LINES * MAX_WIDTH];

  logic [WW-1:0]              eff_w;
  logic [zpwf_pkg::DIM_W-1:0] eff_h;
  logic [TW-1:0]              total, lag, rx_inc;

  logic [CW-1:0]              in_col, out_col;
  logic [SW-1:0]              in_slot, out_slot, rd_slot;
  logic [zpwf_pkg::ROW_W-1:0] out_row;
  logic [TW-1:0]              rx_count, emitted_count;
  logic                       frame_full, write_ok, is_last;

  logic [KW-1:0]              gi, gj;
  logic signed [RS-1:0]       r;
  logic signed [CS-1:0]       c;
  logic signed [STW-1:0]      s;
  logic                       in_frame;
  logic [AW-1:0]              rd_addr, wr_addr;

  logic [7:0]                 rd_data, p;
  logic                       tap_v, tap_in;
  logic signed [3:0]          tap_di, tap_dj;
  logic signed [AC-1:0]       acc, lap_c, pe;
  logic signed [SXW-1:0]      sx, sy, sx_c, sy_c, pe_s, m_in;
  logic signed [2*SXW-1:0]    prod;
  logic [SQW-1:0]             sq, rem, root, sbit;

  // effective frame size
  always_comb begin
    if (cfg.frame_width == '0) begin
      eff_w = WW'(1);
    end else if (int'(cfg.frame_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      eff_h = zpwf_pkg::DIM_W'(1);
    end else if (int'(cfg.frame_height) > zpwf_pkg::MAX_HEIGHT) begin
      eff_h = zpwf_pkg::DIM_W'(zpwf_pkg::MAX_HEIGHT);
    end else begin
      eff_h = cfg.frame_height;
    end
  end

  assign total    = TW'(eff_w) * TW'(eff_h);
  assign lag      = TW'(RAD) * TW'(eff_w) + TW'(RAD);
  assign rx_inc   = rx_count + TW'(1);
  assign write_ok = (req.req_type == zpwf_pkg::REQ_PIXEL) && !frame_full;
  assign is_last  = (emitted_count + TW'(1)) == total;

  assign status.emit_go     = write_ok ? ((rx_inc - emitted_count) > lag) : frame_full;
  assign status.gather_last = (gi == KW'(SPAN - 1)) && (gj == KW'(SPAN - 1));
  assign status.is_sobel    = (cfg.filter_mode == zpwf_pkg::MODE_SOBEL);
  assign status.root_done   = sbit[0];
  assign status.out_free    = !res_valid || res_ready;

  // window tap address
  always_comb begin
    r = $signed({2'b00, out_row}) + $signed(RS'(gi)) - $signed(RS'(RAD));
    c = $signed(CS'(out_col)) + $signed(CS'(gj)) - $signed(CS'(RAD));
    in_frame = (r >= 0) && (r < $signed(RS'(eff_h))) && (c >= 0) && (c < $signed(CS'(eff_w)));
    s = $signed(STW'(out_slot)) + $signed(STW'(gi)) - $signed(STW'(RAD));
    if (s < 0) begin
      s = s + $signed(STW'(LINES));
    end else if (s >= $signed(STW'(LINES))) begin
      s = s - $signed(STW'(LINES));
    end
    rd_slot = SW'(s);
    rd_addr = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(c[CW-1:0]);
    wr_addr = AW'(in_slot) * AW'(MAX_WIDTH) + AW'(in_col);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && write_ok) begin
      mem[wr_addr] <= req.pixel;
    end
    rd_data <= mem[rd_addr];
  end

  // stream position
  always_ff @(posedge clk) begin
    if (rst || cfg_clear || (cmd.finish && is_last)) begin
      in_col        <= '0;
      in_slot       <= '0;
      out_col       <= '0;
      out_row       <= '0;
      out_slot      <= '0;
      rx_count      <= '0;
      emitted_count <= '0;
      frame_full    <= 1'b0;
    end else begin
      if (cmd.accept && write_ok) begin
        rx_count   <= rx_inc;
        frame_full <= (rx_inc >= total);
        if (WW'(in_col) + WW'(1) >= eff_w) begin
          in_col  <= '0;
          in_slot <= (in_slot == SW'(LINES - 1)) ? '0 : in_slot + SW'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (cmd.finish) begin
        emitted_count <= emitted_count + TW'(1);
        if (WW'(out_col) + WW'(1) >= eff_w) begin
          out_col  <= '0;
          out_row  <= out_row + zpwf_pkg::ROW_W'(1);
          out_slot <= (out_slot == SW'(LINES - 1)) ? '0 : out_slot + SW'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  // gather sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_v <= 1'b0;
    end else begin
      tap_v <= cmd.gather;
    end
    if (cmd.accept) begin
      gi <= '0;
      gj <= '0;
    end else if (cmd.gather) begin
      if (gj == KW'(SPAN - 1)) begin
        gj <= '0;
        gi <= gi + KW'(1);
      end else begin
        gj <= gj + KW'(1);
      end
    end
    tap_in <= in_frame;
    tap_di <= 4'(signed'({1'b0, gi})) - 4'(RAD);
    tap_dj <= 4'(signed'({1'b0, gj})) - 4'(RAD);
  end

  // tap weights
  always_comb begin
    p    = tap_in ? rd_data : 8'd0;
    pe   = $signed(AC'(p));
    pe_s = $signed(SXW'(p));
    lap_c = '0;
    if (tap_di == 0 && tap_dj == 0) begin
      lap_c = (cfg.filter_mode == zpwf_pkg::MODE_LAP_CENTRE) ? AC'(5) : AC'(4);
    end else if ((tap_di == 0 && (tap_dj == 1 || tap_dj == -1)) ||
                 (tap_dj == 0 && (tap_di == 1 || tap_di == -1))) begin
      lap_c = -AC'(1);
    end
    sx_c = '0;
    if (tap_di == 1 || tap_di == -1) begin
      if (tap_dj == 0) begin
        sx_c = SXW'(2);
      end else if (tap_dj == 1 || tap_dj == -1) begin
        sx_c = SXW'(1);
      end
      if (tap_di == -1) sx_c = -sx_c;
    end
    sy_c = '0;
    if (tap_dj == 1 || tap_dj == -1) begin
      if (tap_di == 0) begin
        sy_c = SXW'(2);
      end else if (tap_di == 1 || tap_di == -1) begin
        sy_c = SXW'(1);
      end
      if (tap_dj == -1) sy_c = -sy_c;
    end
    m_in = cmd.sq_x ? sx : sy;
    prod = m_in * m_in;
  end

  // accumulate and root
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acc <= '0;
      sx  <= '0;
      sy  <= '0;
    end else if (tap_v) begin
      acc <= acc + ((cfg.filter_mode == zpwf_pkg::MODE_BOX) ? pe : lap_c * pe);
      sx  <= sx + sx_c * pe_s;
      sy  <= sy + sy_c * pe_s;
    end
    if (cmd.sq_x) begin
      sq <= SQW'(prod);
    end
    if (cmd.sq_y) begin
      rem  <= sq + SQW'(prod);
      root <= '0;
      sbit <= SQW'(1) << (SQW - 2);
    end else if (cmd.root_step) begin
      if (rem >= root + sbit) begin
        rem  <= rem - (root + sbit);
        root <= (root >> 1) + sbit;
      end else begin
        root <= root >> 1;
      end
      sbit <= sbit >> 2;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (cmd.finish) begin
      res.filtered_value <= status.is_sobel ? $signed(AC'(root)) : acc;
      res.is_last        <= is_last;
    end
  end

endmodule

>>> rtl/zero_padded_window_filter.sv
// ----------------------------------------------------------------------------
// zero_padded_window_filter
// Zero-padded 2D window filter (Laplacian, Laplacian plus centre, Sobel
// magnitude, box sum) over a raster pixel stream.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------------
//  req     | in        | req_valid/req_ready| req_type, pixel
//  res     | out       | res_valid/res_ready| filtered_value, is_last
//  apb     | in/out    | psel/penable/pready| frame_width, height, mode
//
//  A word that releases a result starts a window sweep: the window is read
//  from the line store one tap a cycle. Sobel mode adds the two squares and
//  the 11-step root unit.
//  Reset is synchronous; the line store needs no clearing pass.
//  A stalled result sits in the output register while the next word is taken.
//
module zero_padded_window_filter #(
  parameter int MAX_WIDTH   = 1024,
  parameter int WINDOW_SIZE = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  zpwf_pkg::in_item_t   req,
  output logic                 res_valid,
  input  logic                 res_ready,
  output zpwf_pkg::out_item_t  res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  zpwf_pkg::cfg_t    cfg;
  zpwf_pkg::cmd_t    cmd;
  zpwf_pkg::status_t status;
  logic              wr_en, cfg_clear;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  // any write to a known register restarts the stream
  assign cfg_clear = wr_en && (reg_idx == zpwf_pkg::REG_WIDTH ||
                               reg_idx == zpwf_pkg::REG_HEIGHT ||
                               reg_idx == zpwf_pkg::REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= zpwf_pkg::DIM_W'(1024);
      cfg.frame_height <= zpwf_pkg::DIM_W'(1024);
      cfg.filter_mode  <= zpwf_pkg::MODE_LAP;
    end else if (wr_en) begin
      unique case (reg_idx)
        zpwf_pkg::REG_WIDTH:  cfg.frame_width  <= pwdata[zpwf_pkg::DIM_W-1:0];
        zpwf_pkg::REG_HEIGHT: cfg.frame_height <= pwdata[zpwf_pkg::DIM_W-1:0];
        zpwf_pkg::REG_MODE:   cfg.filter_mode  <= zpwf_pkg::mode_t'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (reg_idx)
      zpwf_pkg::REG_WIDTH:  prdata = 32'(cfg.frame_width);
      zpwf_pkg::REG_HEIGHT: prdata = 32'(cfg.frame_height);
      zpwf_pkg::REG_MODE:   prdata = 32'(cfg.filter_mode);
      default:              prdata = '0;
    endcase
  end

  zpwf_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  zpwf_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_clear (cfg_clear),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

endmodule

>>> rtl/zpwf_checker.sv
// ----------------------------------------------------------------------------
// zpwf_checker
// Port-level checks on the window filter.
// ----------------------------------------------------------------------------
module zpwf_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input zpwf_pkg::in_item_t  req,
  input logic                res_valid,
  input logic                res_ready,
  input zpwf_pkg::out_item_t res,
  input logic                pready
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request word changed while waiting");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("register port stalled");

endmodule

bind zero_padded_window_filter zpwf_checker u_chk (.*);
